### rtl/dtf_pkg.sv
// Shared types, character codes and the fraction weight table function.
package dtf_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_LEAD,
    PH_INT,
    PH_FRAC,
    PH_TRAIL,
    PH_ERR
  } phase_t;

  // Status that travels from the parser to the result stage
  typedef struct packed {
    logic well_formed;
    logic minus;
    logic clamp;
  } parse_flags_t;

  localparam int SYM_W = 8;
  localparam int OUT_W = 32;

  localparam logic [SYM_W-1:0] CH_TAB   = 8'd9;
  localparam logic [SYM_W-1:0] CH_CR    = 8'd13;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'd32;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'd45;
  localparam logic [SYM_W-1:0] CH_POINT = 8'd46;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [SYM_W-1:0] CH_NINE  = 8'd57;

  // Entries of the digit weight table; the weight reaches zero well before
  // the last entry for any weight width up to 48 bits.
  localparam int WEIGHT_DEPTH = 20;
  localparam int WCNT_W       = $clog2(WEIGHT_DEPTH);

  // Weight of the fraction digit at position k (k digits already taken):
  // start at 0.1 rounded, then divide by ten rounding half up per digit.
  function automatic logic [63:0] weight_at(input int wbits, input int k);
    logic [63:0] w;
    w = ((64'd1 << wbits) + 64'd5) / 64'd10;
    for (int i = 0; i < k; i++) begin
      w = (w + 64'd5) / 64'd10;
    end
    return w;
  endfunction

endpackage

### rtl/dtf_if.sv
// Valid/ready channel interfaces for characters in and parse results out.
interface dtf_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtf_pkg::SYM_W-1:0]      symbol;
  logic                           finish;

  modport source (output valid, output symbol, output finish, input ready);
  modport sink   (input valid, input symbol, input finish, output ready);
endinterface

interface dtf_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [dtf_pkg::OUT_W-1:0] result_value;
  logic                           well_formed;
  logic                           saturated;

  modport source (output valid, output result_value, output well_formed,
                  output saturated, input ready);
  modport sink   (input valid, input result_value, input well_formed,
                  input saturated, output ready);
endinterface

### rtl/dtf_in_reg.sv
// Input register: holds one accepted character request until it is consumed.
module dtf_in_reg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [dtf_pkg::SYM_W-1:0] in_symbol,
  input  logic                      in_finish,
  input  logic                      consume,
  output logic                      q_valid,
  output logic [dtf_pkg::SYM_W-1:0] q_symbol,
  output logic                      q_finish
);

  logic                      valid_r;
  logic [dtf_pkg::SYM_W-1:0] symbol_r;
  logic                      finish_r;

  assign in_ready = !valid_r || consume;
  assign q_valid  = valid_r;
  assign q_symbol = symbol_r;
  assign q_finish = finish_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (consume) begin
      valid_r <= 1'b0;
    end
  end

  // Payload: load on accept only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      symbol_r <= in_symbol;
      finish_r <= in_finish;
    end
  end

endmodule

### rtl/dtf_parse.sv
// Parse state machine with saturating integer and fraction accumulators.
module dtf_parse #(
  parameter int INT_BITS    = 15,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      clear,
  input  logic [dtf_pkg::SYM_W-1:0] symbol,
  output logic [INT_BITS-1:0]       whole,
  output logic [WEIGHT_BITS-1:0]    frac_sum,
  output dtf_pkg::parse_flags_t     flags
);

  localparam logic [INT_BITS-1:0]    WHOLE_MAX = {INT_BITS{1'b1}};
  localparam logic [WEIGHT_BITS-1:0] FRAC_MAX  = {WEIGHT_BITS{1'b1}};

  dtf_pkg::phase_t               phase_r, phase_nxt;
  logic                          minus_r, minus_nxt;
  logic                          clamp_r, clamp_nxt;
  logic [INT_BITS-1:0]           whole_r, whole_nxt;
  logic [WEIGHT_BITS-1:0]        frac_r, frac_nxt;
  logic [dtf_pkg::WCNT_W-1:0]    cnt_r, cnt_nxt;

  logic [WEIGHT_BITS-1:0]        wtab [dtf_pkg::WEIGHT_DEPTH];

  logic                          is_blank, is_digit, is_sign;
  logic [3:0]                    digit;
  logic                          take_whole, take_frac, take_sign;
  logic [INT_BITS+3:0]           whole_prod;
  logic [WEIGHT_BITS+4:0]        frac_add;

  for (genvar k = 0; k < dtf_pkg::WEIGHT_DEPTH; k++) begin : g_wtab
    assign wtab[k] = WEIGHT_BITS'(dtf_pkg::weight_at(WEIGHT_BITS, k));
  end

  always_comb begin
    is_blank = (symbol == dtf_pkg::CH_SPACE) ||
               ((symbol >= dtf_pkg::CH_TAB) && (symbol <= dtf_pkg::CH_CR));
    is_digit = (symbol >= dtf_pkg::CH_ZERO) && (symbol <= dtf_pkg::CH_NINE);
    is_sign  = (symbol == dtf_pkg::CH_PLUS) || (symbol == dtf_pkg::CH_MINUS);
    digit    = 4'(symbol - dtf_pkg::CH_ZERO);
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      dtf_pkg::PH_LEAD: begin
        if (is_blank) begin
          phase_nxt = dtf_pkg::PH_LEAD;
        end else if (is_sign || is_digit) begin
          phase_nxt = dtf_pkg::PH_INT;
        end else if (symbol == dtf_pkg::CH_POINT) begin
          phase_nxt = dtf_pkg::PH_FRAC;
        end else begin
          phase_nxt = dtf_pkg::PH_ERR;
        end
      end
      dtf_pkg::PH_INT: begin
        if (is_digit) begin
          phase_nxt = dtf_pkg::PH_INT;
        end else if (symbol == dtf_pkg::CH_POINT) begin
          phase_nxt = dtf_pkg::PH_FRAC;
        end else if (is_blank) begin
          phase_nxt = dtf_pkg::PH_TRAIL;
        end else begin
          phase_nxt = dtf_pkg::PH_ERR;
        end
      end
      dtf_pkg::PH_FRAC: begin
        if (is_digit) begin
          phase_nxt = dtf_pkg::PH_FRAC;
        end else if (is_blank) begin
          phase_nxt = dtf_pkg::PH_TRAIL;
        end else begin
          phase_nxt = dtf_pkg::PH_ERR;
        end
      end
      dtf_pkg::PH_TRAIL: begin
        phase_nxt = is_blank ? dtf_pkg::PH_TRAIL : dtf_pkg::PH_ERR;
      end
      default: begin
        phase_nxt = dtf_pkg::PH_ERR;
      end
    endcase
  end

  // Actions for the current character
  always_comb begin
    take_whole = 1'b0;
    take_frac  = 1'b0;
    take_sign  = 1'b0;
    case (phase_r)
      dtf_pkg::PH_LEAD: begin
        take_sign  = !is_blank && is_sign;
        take_whole = !is_blank && is_digit;
      end
      dtf_pkg::PH_INT: begin
        take_whole = is_digit;
      end
      dtf_pkg::PH_FRAC: begin
        take_frac = is_digit;
      end
      default: begin
        take_whole = 1'b0;
      end
    endcase
  end

  // Accumulator updates
  always_comb begin
    whole_prod = {whole_r, 3'b000} + {3'b000, whole_r, 1'b0} +
                 (INT_BITS+4)'(digit);
    frac_add   = (WEIGHT_BITS+5)'(frac_r) + (WEIGHT_BITS+5)'(wtab[cnt_r] * digit);

    minus_nxt = minus_r;
    clamp_nxt = clamp_r;
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;

    if (take_sign) begin
      minus_nxt = (symbol == dtf_pkg::CH_MINUS);
    end
    if (take_whole) begin
      if (whole_prod > (INT_BITS+4)'(WHOLE_MAX)) begin
        whole_nxt = WHOLE_MAX;
        clamp_nxt = 1'b1;
      end else begin
        whole_nxt = whole_prod[INT_BITS-1:0];
      end
    end
    if (take_frac) begin
      frac_nxt = (frac_add > (WEIGHT_BITS+5)'(FRAC_MAX)) ? FRAC_MAX
                                                         : frac_add[WEIGHT_BITS-1:0];
      if (cnt_r != dtf_pkg::WCNT_W'(dtf_pkg::WEIGHT_DEPTH - 1)) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= dtf_pkg::PH_LEAD;
      minus_r <= 1'b0;
      clamp_r <= 1'b0;
      whole_r <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      minus_r <= minus_nxt;
      clamp_r <= clamp_nxt;
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign whole             = whole_r;
  assign frac_sum          = frac_r;
  assign flags.well_formed = (phase_r != dtf_pkg::PH_ERR);
  assign flags.minus       = minus_r;
  assign flags.clamp       = clamp_r;

endmodule

### rtl/dtf_result.sv
// Result stage: rounds and caps the magnitude, applies the sign, holds the result.
module dtf_result #(
  parameter int INT_BITS    = 15,
  parameter int FRAC_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  output logic                               free,
  input  logic [INT_BITS-1:0]                whole,
  input  logic [WEIGHT_BITS-1:0]             frac_sum,
  input  dtf_pkg::parse_flags_t              flags,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dtf_pkg::OUT_W-1:0]   out_result_value,
  output logic                               out_well_formed,
  output logic                               out_saturated
);

  localparam int MAG_W = INT_BITS + FRAC_BITS + 1;
  localparam int CW    = (MAG_W > dtf_pkg::OUT_W) ? MAG_W : dtf_pkg::OUT_W;
  localparam logic [CW-1:0] CAP = (INT_BITS + FRAC_BITS >= 31)
                                  ? CW'(32'h7FFF_FFFF)
                                  : ((CW'(1) << (INT_BITS + FRAC_BITS)) - CW'(1));

  logic [FRAC_BITS:0]              frac_rnd;
  logic [MAG_W-1:0]                mag;
  logic [CW-1:0]                   mag_ext, mag_cap;
  logic [dtf_pkg::OUT_W-1:0]       mag32;

  logic                            valid_r;
  logic [dtf_pkg::OUT_W-1:0]       value_r;
  logic                            wf_r, sat_r;

  // Fraction to FRAC_BITS, rounded half up
  if (WEIGHT_BITS > FRAC_BITS) begin : g_round
    localparam int SH = WEIGHT_BITS - FRAC_BITS;
    logic [WEIGHT_BITS:0] frac_biased;
    assign frac_biased = {1'b0, frac_sum} + ((WEIGHT_BITS+1)'(1) << (SH - 1));
    assign frac_rnd    = frac_biased[WEIGHT_BITS:SH];
  end else if (WEIGHT_BITS == FRAC_BITS) begin : g_same
    assign frac_rnd = {1'b0, frac_sum};
  end else begin : g_widen
    assign frac_rnd = {1'b0, frac_sum, {(FRAC_BITS - WEIGHT_BITS){1'b0}}};
  end

  always_comb begin
    mag     = {1'b0, whole, {FRAC_BITS{1'b0}}} + MAG_W'(frac_rnd);
    mag_ext = CW'(mag);
    mag_cap = (mag_ext > CAP) ? CAP : mag_ext;
    mag32   = mag_cap[dtf_pkg::OUT_W-1:0];
  end

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value_r <= flags.minus ? (dtf_pkg::OUT_W'(0) - mag32) : mag32;
      wf_r    <= flags.well_formed;
      sat_r   <= flags.clamp;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_value = signed'(value_r);
  assign out_well_formed  = wf_r;
  assign out_saturated    = sat_r;

endmodule

### rtl/decimal_text_to_fixed_top.sv
// Top level of the decimal text to fixed-point parser.
//
// Usage:
//   in_chan carries one character request per transfer (symbol, finish).
//   Ordinary characters advance the parse and produce nothing; a request
//   with finish high ends the string, produces one result on out_chan and
//   returns the parser to its start state. symbol is ignored on finish.
//   out_chan carries result_value (signed, FRAC_BITS fraction bits, capped
//   at 2^31-1 in magnitude), well_formed and saturated.
// Throughput and flow:
//   One request per cycle, while no finish waits on a busy result register.
//   A request is held in the input register, then updates the parse state
//   or loads the result register.
// Stall behavior:
//   While a result waits on out_chan, characters keep flowing; only a
//   second finish waits in the input register until the result is taken.
// Reset:
//   rst_n (synchronous, active low) empties both registers and puts the
//   parser at the start of a string with zero value.
module decimal_text_to_fixed_top #(
  parameter int INT_BITS    = 15,
  parameter int FRAC_BITS   = 16,
  parameter int WEIGHT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  dtf_in_if.sink       in_chan,
  dtf_out_if.source    out_chan
);

  logic                      q_valid;
  logic [dtf_pkg::SYM_W-1:0] q_symbol;
  logic                      q_finish;
  logic                      consume;
  logic                      res_free;
  logic [INT_BITS-1:0]       whole;
  logic [WEIGHT_BITS-1:0]    frac_sum;
  dtf_pkg::parse_flags_t     flags;

  // Advance a character always; advance a finish only when the result
  // register can take it.
  assign consume = q_valid && (!q_finish || res_free);

  dtf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_symbol (in_chan.symbol),
    .in_finish (in_chan.finish),
    .consume   (consume),
    .q_valid   (q_valid),
    .q_symbol  (q_symbol),
    .q_finish  (q_finish)
  );

  dtf_parse #(
    .INT_BITS    (INT_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (consume && !q_finish),
    .clear    (consume && q_finish),
    .symbol   (q_symbol),
    .whole    (whole),
    .frac_sum (frac_sum),
    .flags    (flags)
  );

  // Capture the result from the current parse state on the finish request
  dtf_result #(
    .INT_BITS    (INT_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_result (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (consume && q_finish),
    .free             (res_free),
    .whole            (whole),
    .frac_sum         (frac_sum),
    .flags            (flags),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_result_value (out_chan.result_value),
    .out_well_formed  (out_chan.well_formed),
    .out_saturated    (out_chan.saturated)
  );

endmodule
